// ===== rtl/core/gravity_well_particle_step_top_assert.svh =====
// ----------------------------------------------------------------------------
// Gravity well particle step - assertion macros
// Clocked, reset-qualified assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_WELL_PARTICLE_STEP_TOP_ASSERT_SVH
`define GRAVITY_WELL_PARTICLE_STEP_TOP_ASSERT_SVH

// Concurrent assertion on aclk, idle while aresetn is low.
`define GWPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Same-cycle implication form.
`define GWPS_ASSERT_IMP(lbl, ante, cons, msg) \
    `GWPS_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define GWPS_ASSERT_NXT(lbl, ante, cons, msg) \
    `GWPS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/gwps_pkg.sv =====
// ----------------------------------------------------------------------------
// gwps_pkg
// Types, register map, constants and saturation helper for the gravity well.
// ----------------------------------------------------------------------------
package gwps_pkg;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_ATTRACT_GAIN = 2'd0;
    localparam logic [1:0] REG_VEL_DAMPING  = 2'd1;
    localparam logic [1:0] REG_RETGT_DIST   = 2'd2;
    localparam logic [1:0] REG_PULL_STR     = 2'd3;

    localparam logic [15:0] ATTRACT_GAIN_RST = 16'd328;
    localparam logic [16:0] VEL_DAMPING_RST  = 17'd62259;
    localparam logic [30:0] RETGT_DIST_RST   = 31'd655360;
    localparam logic [30:0] PULL_STR_RST     = 31'd32768;

    localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TGT_XY_OFS = 32'sd983040;   // 15.0
    localparam logic signed [31:0] TGT_Z_OFS  = 32'sd327680;   // 5.0
    localparam logic [63:0]        RECIP_NUM  = 64'h1_0000_0000;

    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        CMD_TICK     = 1'b0,
        CMD_PARTICLE = 1'b1
    } gwps_cmd_t;

    typedef struct packed {
        logic               command;
        logic [15:0]        rand_x;
        logic [15:0]        rand_y;
        logic [15:0]        rand_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] spin;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_spin;
        logic signed [31:0] well_x;
        logic signed [31:0] well_y;
        logic signed [31:0] well_z;
        logic               retargeted;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [30:0] quot;
    } div_res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OFF,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_GAIN_MUL,
        ST_VEL,
        ST_POS,
        ST_DAMP,
        ST_RETGT,
        ST_ZERO,
        ST_PULL_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RECIP_START,
        ST_RECIP_WAIT,
        ST_DONE
    } gwps_state_t;

    // {clip, value}: clamp a wide signed value to 32 bits
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gravity_well_particle_step_top.sv =====
// ----------------------------------------------------------------------------
// gravity_well_particle_step_top
// Gravity well state with tick update and per-particle pull, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data take one request (tick or particle); the block
//   returns one result on m_valid/m_ready/m_data for every request. The user
//   writes APB port registers 0x0, 0x4, 0x8, 0xC only while idle, unenforced.
// Timing:
//   One request is in work at a time; s_ready drops after an accept.
//   Squares and per-axis gain/damping products all go through one shared
//   33x33 multiplier. A particle runs three pulls and the reciprocal each
//   through the 31-step restoring divider, one quotient bit a cycle; a
//   quotient that overflows ends its division before any step instead.
//   A zero distance skips the divider.
// Reset: well position, velocity and target clear, registers go to defaults,
//   no result is pending.
// Stall: a finished result sits in the output register; the next request is
//   accepted meanwhile, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module gravity_well_particle_step_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  gwps_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output gwps_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gwps_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import gwps_pkg::*;

    // configuration
    logic [15:0] gain_reg;
    logic [16:0] damp_reg;
    logic [30:0] rdist_reg;
    logic [30:0] pstr_reg;

    gwps_state_t state_reg, state_next;
    logic [1:0]  ax_reg, ax_next;
    in_item_t    item_reg, item_next;
    logic        clip_reg, clip_next;
    logic        retgt_reg, retgt_next;
    logic [63:0] d_reg, d_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;

    logic signed [31:0] wpos_reg [3];
    logic signed [31:0] wpos_next [3];
    logic signed [31:0] wvel_reg [3];
    logic signed [31:0] wvel_next [3];
    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] tgt_next [3];
    logic signed [31:0] off_reg [3];
    logic signed [31:0] off_next [3];
    logic signed [31:0] nvel_reg [3];
    logic signed [31:0] nvel_next [3];
    logic signed [31:0] spin_reg, spin_next;

    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_vel [3];

    logic        div_start;
    logic [63:0] div_num;
    div_res_t    div_res;

    logic        cfg_wr;

    logic [32:0]        sres;
    logic [31:0]        off_mag;
    logic [31:0]        quo;
    logic signed [65:0] pull;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_ATTRACT_GAIN: prdata = {16'd0, gain_reg};
            REG_VEL_DAMPING:  prdata = {15'd0, damp_reg};
            REG_RETGT_DIST:   prdata = {1'b0, rdist_reg};
            REG_PULL_STR:     prdata = {1'b0, pstr_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= ATTRACT_GAIN_RST;
            damp_reg  <= VEL_DAMPING_RST;
            rdist_reg <= RETGT_DIST_RST;
            pstr_reg  <= PULL_STR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ATTRACT_GAIN: gain_reg  <= pwdata[15:0];
                REG_VEL_DAMPING:  damp_reg  <= pwdata[16:0];
                REG_RETGT_DIST:   rdist_reg <= pwdata[30:0];
                REG_PULL_STR:     pstr_reg  <= pwdata[30:0];
                default:          ;
            endcase
        end
    end

    assign in_pos[0] = item_reg.pos_x;
    assign in_pos[1] = item_reg.pos_y;
    assign in_pos[2] = item_reg.pos_z;
    assign in_vel[0] = item_reg.vel_x;
    assign in_vel[1] = item_reg.vel_y;
    assign in_vel[2] = item_reg.vel_z;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    gwps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (d_reg),
        .res     (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                wpos_reg[i] <= '0;
                wvel_reg[i] <= '0;
                tgt_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 3; i++) begin
                wpos_reg[i] <= wpos_next[i];
                wvel_reg[i] <= wvel_next[i];
                tgt_reg[i]  <= tgt_next[i];
            end
        end
        ax_reg     <= ax_next;
        item_reg   <= item_next;
        clip_reg   <= clip_next;
        retgt_reg  <= retgt_next;
        d_reg      <= d_next;
        prod_reg   <= mul_a * mul_b;
        spin_reg   <= spin_next;
        m_data_reg <= m_data_next;
        for (int i = 0; i < 3; i++) begin
            off_reg[i]  <= off_next[i];
            nvel_reg[i] <= nvel_next[i];
        end
    end

    always_comb begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        item_next    = item_reg;
        clip_next    = clip_reg;
        retgt_next   = retgt_reg;
        d_next       = d_reg;
        spin_next    = spin_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wpos_next    = wpos_reg;
        wvel_next    = wvel_reg;
        tgt_next     = tgt_reg;
        off_next     = off_reg;
        nvel_next    = nvel_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = RECIP_NUM;
        sres         = '0;
        pull         = '0;
        off_mag      = 32'(-{off_reg[ax_reg][31], off_reg[ax_reg]});
        if (!off_reg[ax_reg][31]) begin
            off_mag = off_reg[ax_reg];
        end
        quo = div_res.ovf ? 32'h7FFF_FFFF : {1'b0, div_res.quot};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    clip_next  = 1'b0;
                    retgt_next = 1'b0;
                    d_next     = '0;
                    ax_next    = '0;
                    state_next = ST_OFF;
                end
            end
            ST_OFF: begin
                for (int i = 0; i < 3; i++) begin
                    if (item_reg.command == CMD_PARTICLE) begin
                        sres = sat32(66'(wpos_reg[i]) - 66'(in_pos[i]));
                        clip_next = clip_next | sres[32];
                    end else begin
                        sres = sat32(66'(tgt_reg[i]) - 66'(wpos_reg[i]));
                    end
                    off_next[i] = sres[31:0];
                end
                state_next = ST_SQ_MUL;
            end
            ST_SQ_MUL: begin
                mul_a      = 33'(off_reg[ax_reg]);
                mul_b      = 33'(off_reg[ax_reg]);
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                d_next = d_reg + prod_reg[63:0];
                if (ax_reg == 2'd2) begin
                    ax_next = '0;
                    if (item_reg.command == CMD_TICK) begin
                        state_next = ST_GAIN_MUL;
                    end else if (d_next == '0) begin
                        state_next = ST_ZERO;
                    end else begin
                        state_next = ST_PULL_MUL;
                    end
                end else begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_GAIN_MUL: begin
                mul_a      = 33'(off_reg[ax_reg]);
                mul_b      = $signed({17'd0, gain_reg});
                state_next = ST_VEL;
            end
            ST_VEL: begin
                sres = sat32(66'(wvel_reg[ax_reg]) + (prod_reg >>> 16));
                wvel_next[ax_reg] = sres[31:0];
                state_next = ST_POS;
            end
            ST_POS: begin
                sres = sat32(66'(wpos_reg[ax_reg]) + 66'(wvel_reg[ax_reg]));
                wpos_next[ax_reg] = sres[31:0];
                mul_a      = 33'(wvel_reg[ax_reg]);
                mul_b      = $signed({16'd0, damp_reg});
                state_next = ST_DAMP;
            end
            ST_DAMP: begin
                sres = sat32(prod_reg >>> 16);
                wvel_next[ax_reg] = sres[31:0];
                if (ax_reg == 2'd2) begin
                    state_next = ST_RETGT;
                end else begin
                    ax_next    = ax_reg + 1'b1;
                    state_next = ST_GAIN_MUL;
                end
            end
            ST_RETGT: begin
                // distance was taken before the move
                if (d_reg < {17'd0, rdist_reg, 16'd0}) begin
                    retgt_next  = 1'b1;
                    tgt_next[0] = $signed(32'(item_reg.rand_x) * 32'd30) - TGT_XY_OFS;
                    tgt_next[1] = $signed(32'(item_reg.rand_y) * 32'd30) - TGT_XY_OFS;
                    tgt_next[2] = $signed(32'(item_reg.rand_z) * 32'd10) - TGT_Z_OFS;
                end
                state_next = ST_DONE;
            end
            ST_ZERO: begin
                // particle on the well: no pull, reciprocal pinned at max
                nvel_next  = in_vel;
                sres       = sat32(66'(item_reg.spin) + 66'(Q_MAX));
                spin_next  = sres[31:0];
                clip_next  = 1'b1;
                state_next = ST_DONE;
            end
            ST_PULL_MUL: begin
                mul_a      = $signed({1'b0, off_mag});
                mul_b      = $signed({2'd0, pstr_reg});
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                div_num    = prod_reg[63:0];
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    pull = $signed({34'd0, quo});
                    if (off_reg[ax_reg][31]) begin
                        pull = -pull;
                    end
                    sres = sat32(66'(in_vel[ax_reg]) + pull);
                    nvel_next[ax_reg] = sres[31:0];
                    clip_next = clip_reg | sres[32] | div_res.ovf;
                    if (ax_reg == 2'd2) begin
                        state_next = ST_RECIP_START;
                    end else begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_PULL_MUL;
                    end
                end
            end
            ST_RECIP_START: begin
                div_start  = 1'b1;
                div_num    = RECIP_NUM;
                state_next = ST_RECIP_WAIT;
            end
            ST_RECIP_WAIT: begin
                if (div_res.done) begin
                    sres = sat32(66'(item_reg.spin) + $signed({34'd0, quo}));
                    spin_next  = sres[31:0];
                    clip_next  = clip_reg | sres[32] | div_res.ovf;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.well_x     = wpos_reg[0];
                    m_data_next.well_y     = wpos_reg[1];
                    m_data_next.well_z     = wpos_reg[2];
                    m_data_next.retargeted = retgt_reg;
                    if (item_reg.command == CMD_PARTICLE) begin
                        m_data_next.new_vel_x = nvel_reg[0];
                        m_data_next.new_vel_y = nvel_reg[1];
                        m_data_next.new_vel_z = nvel_reg[2];
                        m_data_next.new_spin  = spin_reg;
                        m_data_next.saturated = clip_reg;
                    end else begin
                        m_data_next.new_vel_x = '0;
                        m_data_next.new_vel_y = '0;
                        m_data_next.new_vel_z = '0;
                        m_data_next.new_spin  = '0;
                        m_data_next.saturated = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/gwps_div.sv =====
// ----------------------------------------------------------------------------
// gwps_div
// Radix-2 restoring divider: floor(num * 2^16 / den), overflow flagged at 2^31.
// ----------------------------------------------------------------------------
module gwps_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       num,
    input  logic [63:0]       den,
    output gwps_pkg::div_res_t res
);
    import gwps_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          rem_reg, rem_next;
    logic [30:0]          sh_reg, sh_next;
    logic [30:0]          q_reg, q_next;

    logic [63:0] r0;
    logic [64:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        // top of the shifted numerator; quotient overflows when this reaches den
        r0    = {15'd0, num[63:15]};
        trial = {rem_reg, sh_reg[30]};
        if (start) begin
            q_next   = '0;
            rem_next = r0;
            sh_next  = {num[14:0], 16'd0};
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            if (r0 >= den) begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, den}) begin
                rem_next = 64'(trial - {1'b0, den});
                q_next   = {q_reg[29:0], 1'b1};
            end else begin
                rem_next = trial[63:0];
                q_next   = {q_reg[29:0], 1'b0};
            end
            sh_next  = {sh_reg[29:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = q_reg;

endmodule

// ===== rtl/core/gwps_checker.sv =====
// ----------------------------------------------------------------------------
// gwps_checker
// Port-level checks on request and result channels of the gravity well block.
// ----------------------------------------------------------------------------
`include "gravity_well_particle_step_top_assert.svh"

module gwps_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input gwps_pkg::out_item_t m_data
);
    import gwps_pkg::*;

    `GWPS_ASSERT_NXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped under stall")
    `GWPS_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "second request taken while busy")
    `GWPS_ASSERT_IMP(a_retgt_is_tick, m_valid && m_data.retargeted, !m_data.saturated && m_data.new_spin == '0, "retarget flagged on a particle result")

endmodule

bind gravity_well_particle_step_top gwps_checker u_gwps_checker (.*);
